// File: src/msps_pkg.sv
// ----------------------------------------------------------------------------
// msps_pkg
// Shared types and constants for the motion segment path stepper: field
// widths, operation and status codes, and the step divider request and
// response words.
// ----------------------------------------------------------------------------
package msps_pkg;

    // field widths
    localparam int POS_W   = 32;
    localparam int STEP_W  = 24;
    localparam int TICKS_W = 16;
    localparam int LIFE_W  = 24;
    localparam int SEG_W   = 2 * STEP_W + TICKS_W;

    // iteration counter of the step divider, holds STEP_W itself
    localparam int DIV_CNT_W = $clog2(STEP_W + 1);

    // default queue depth
    localparam int QUEUE_DEPTH_DEF = 16;

    // operation codes on s_func
    localparam logic [1:0] FUNC_TICK    = 2'd0;
    localparam logic [1:0] FUNC_APPEND  = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_FULL       = 2'd1;
    localparam logic [1:0] STATUS_ZERO_TICKS = 2'd2;

    // configuration register indexes
    localparam logic CFG_REPEAT_PATH = 1'b0;
    localparam logic CFG_TOTAL_LIFE  = 1'b1;

    // step divider request: start pulse, signed dividend, nonzero divisor
    typedef struct packed {
        logic                      start;
        logic signed [STEP_W-1:0]  dividend;
        logic        [TICKS_W-1:0] divisor;
    } div_req_t;

    // step divider response: one-cycle done pulse with the quotient
    typedef struct packed {
        logic                     done;
        logic signed [STEP_W-1:0] quotient;
    } div_rsp_t;

endpackage

// File: src/motion_segment_path_stepper_top.sv
// ----------------------------------------------------------------------------
// motion_segment_path_stepper_top
// Moves one point along a queue of straight segments: append, tick, restart.
// ----------------------------------------------------------------------------
// One word in gives one result word out. Items are handled one at a time:
// a tick on a nonempty queue goes from accept through the queue memory
// read and the position update to the result; a tick on an empty queue,
// a restart, a rejected append or an unused code goes straight from accept
// to the result; an accepted append passes through the shared serial
// divider, which works out the x step and then the y step (start, one
// quotient bit per cycle for 24 bits, done), before the result. A new word
// is taken while the previous result still waits in the output register.
// The segment queue is a memory of QUEUE_DEPTH 64-bit entries with a
// registered read port; it needs no clearing after reset, since only written
// entries are ever read. Configuration writes are taken in every cycle.
module motion_segment_path_stepper_top
    import msps_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int PTR_W = $clog2(QUEUE_DEPTH),
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    // configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [LIFE_W-1:0]         cfg_data,

    // input channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_func,
    input  logic signed [STEP_W-1:0]  s_seg_dx,
    input  logic signed [STEP_W-1:0]  s_seg_dy,
    input  logic [TICKS_W-1:0]        s_seg_ticks,
    input  logic signed [POS_W-1:0]   s_new_x,
    input  logic signed [POS_W-1:0]   s_new_y,

    // result channel
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [POS_W-1:0]   m_pos_x,
    output logic signed [POS_W-1:0]   m_pos_y,
    output logic [LIFE_W-1:0]         m_ticks_lived,
    output logic                      m_expired,
    output logic [CNT_W-1:0]          m_queued_segments,
    output logic [1:0]                m_status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK_RD,
        ST_TICK_APPLY,
        ST_DIV_X,
        ST_DIV_Y,
        ST_DONE
    } state_t;

    state_t                  state_reg;

    // configuration
    logic                    repeat_path_reg;
    logic [LIFE_W-1:0]       total_life_reg;

    // path state
    logic [TICKS_W-1:0]      head_left_reg;
    logic [PTR_W-1:0]        head_reg;
    logic [PTR_W-1:0]        tail_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [POS_W-1:0]        pos_x_reg;
    logic [POS_W-1:0]        pos_y_reg;
    logic [LIFE_W-1:0]       tick_count_reg;

    // per-item working registers
    logic [1:0]              status_reg;
    logic signed [STEP_W-1:0] dy_reg;
    logic [TICKS_W-1:0]      ticks_reg;
    logic [STEP_W-1:0]       step_x_reg;

    // result register
    logic                    m_valid_reg;
    logic [POS_W-1:0]        m_pos_x_reg;
    logic [POS_W-1:0]        m_pos_y_reg;
    logic [LIFE_W-1:0]       m_ticks_reg;
    logic                    m_expired_reg;
    logic [CNT_W-1:0]        m_count_reg;
    logic [1:0]              m_status_reg;

    // segment queue memory
    logic [SEG_W-1:0]        seg_mem [QUEUE_DEPTH];
    logic [SEG_W-1:0]        rd_data_reg;
    logic                    mem_we;
    logic [SEG_W-1:0]        mem_wdata;

    div_req_t                div_req;
    div_rsp_t                div_rsp;

    logic                    s_accept;
    logic [TICKS_W-1:0]      left_now;
    logic                    seg_last;
    logic [POS_W-1:0]        step_x_ext;
    logic [POS_W-1:0]        step_y_ext;

    // wrap a queue pointer at the depth
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;

    // head segment as read from the queue
    assign left_now   = (head_left_reg == '0) ? rd_data_reg[TICKS_W-1:0] : head_left_reg;
    assign seg_last   = (left_now[TICKS_W-1:1] == '0);
    assign step_x_ext = {{(POS_W-STEP_W){rd_data_reg[SEG_W-1]}},
                         rd_data_reg[SEG_W-1 -: STEP_W]};
    assign step_y_ext = {{(POS_W-STEP_W){rd_data_reg[TICKS_W+STEP_W-1]}},
                         rd_data_reg[TICKS_W +: STEP_W]};

    // divider requests: x step on accept, y step when x is done
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = s_seg_dx;
        div_req.divisor  = s_seg_ticks;
        if (state_reg == ST_IDLE) begin
            div_req.start = s_accept && (s_func == FUNC_APPEND) &&
                            (s_seg_ticks != '0) && (count_reg < CNT_W'(QUEUE_DEPTH));
        end else if (state_reg == ST_DIV_X) begin
            div_req.start    = div_rsp.done;
            div_req.dividend = dy_reg;
            div_req.divisor  = ticks_reg;
        end
    end

    // queue write: new segment at the end of the y division, or requeue in repeat
    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = rd_data_reg;
        if (state_reg == ST_DIV_Y && div_rsp.done) begin
            mem_we    = 1'b1;
            mem_wdata = {step_x_reg, div_rsp.quotient, ticks_reg};
        end else if (state_reg == ST_TICK_APPLY && seg_last && repeat_path_reg) begin
            mem_we = 1'b1;
        end
    end

    // queue memory, registered read at the head
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            seg_mem[tail_reg] <= mem_wdata;
        end
        rd_data_reg <= seg_mem[head_reg];
    end

    msps_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // sequencer, path state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            repeat_path_reg <= 1'b0;
            total_life_reg  <= '0;
            head_left_reg   <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            tick_count_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_REPEAT_PATH: repeat_path_reg <= cfg_data[0];
                    CFG_TOTAL_LIFE:  total_life_reg  <= cfg_data;
                    default:         ;
                endcase
            end

            // output register empties when its word is taken and nothing new loads
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        dy_reg    <= s_seg_dy;
                        ticks_reg <= s_seg_ticks;
                        unique case (s_func)
                            FUNC_TICK: begin
                                status_reg <= STATUS_OK;
                                state_reg  <= (count_reg != '0) ? ST_TICK_RD : ST_DONE;
                            end
                            FUNC_APPEND: begin
                                if (s_seg_ticks == '0) begin
                                    status_reg <= STATUS_ZERO_TICKS;
                                    state_reg  <= ST_DONE;
                                end else if (count_reg >= CNT_W'(QUEUE_DEPTH)) begin
                                    status_reg <= STATUS_FULL;
                                    state_reg  <= ST_DONE;
                                end else begin
                                    status_reg <= STATUS_OK;
                                    state_reg  <= ST_DIV_X;
                                end
                            end
                            FUNC_RESTART: begin
                                status_reg     <= STATUS_OK;
                                state_reg      <= ST_DONE;
                                head_left_reg  <= '0;
                                head_reg       <= '0;
                                tail_reg       <= '0;
                                count_reg      <= '0;
                                pos_x_reg      <= s_new_x;
                                pos_y_reg      <= s_new_y;
                                tick_count_reg <= '0;
                            end
                            default: begin
                                status_reg <= STATUS_OK;
                                state_reg  <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_TICK_RD: begin
                    state_reg <= ST_TICK_APPLY;
                end
                ST_TICK_APPLY: begin
                    pos_x_reg <= pos_x_reg + step_x_ext;
                    pos_y_reg <= pos_y_reg + step_y_ext;
                    if (seg_last) begin
                        head_left_reg <= '0;
                        head_reg      <= ptr_inc(head_reg);
                        if (repeat_path_reg) begin
                            tail_reg <= ptr_inc(tail_reg);
                        end else begin
                            count_reg <= count_reg - 1'b1;
                        end
                    end else begin
                        head_left_reg <= left_now - 1'b1;
                    end
                    if (tick_count_reg != '1) begin
                        tick_count_reg <= tick_count_reg + 1'b1;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DIV_X: begin
                    if (div_rsp.done) begin
                        step_x_reg <= div_rsp.quotient;
                        state_reg  <= ST_DIV_Y;
                    end
                end
                ST_DIV_Y: begin
                    if (div_rsp.done) begin
                        tail_reg  <= ptr_inc(tail_reg);
                        count_reg <= count_reg + 1'b1;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // load the result once the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg   <= 1'b1;
                        m_pos_x_reg   <= pos_x_reg;
                        m_pos_y_reg   <= pos_y_reg;
                        m_ticks_reg   <= tick_count_reg;
                        m_expired_reg <= (total_life_reg != '0) &&
                                         (tick_count_reg == total_life_reg);
                        m_count_reg   <= count_reg;
                        m_status_reg  <= status_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_pos_x           = m_pos_x_reg;
    assign m_pos_y           = m_pos_y_reg;
    assign m_ticks_lived     = m_ticks_reg;
    assign m_expired         = m_expired_reg;
    assign m_queued_segments = m_count_reg;
    assign m_status          = m_status_reg;

    // the queue never holds more segments than it has entries
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("segment count above queue depth");

    // a segment in progress implies a nonempty queue
    a_head_needs_segment: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_left_reg != '0) |-> (count_reg != '0))
        else $error("head ticks left with an empty queue");

    // divider results only arrive while an append is dividing
    a_div_done_in_append: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DIV_X || state_reg == ST_DIV_Y))
        else $error("divider done outside an append");

    // the divider has nothing left to deliver once an item has finished
    a_append_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && $past(state_reg) != ST_IDLE && $past(aresetn)
         && state_reg != $past(state_reg)) |-> !div_rsp.done)
        else $error("divider still busy after item finished");

endmodule

// File: src/msps_div.sv
// ----------------------------------------------------------------------------
// msps_div
// Serial restoring divider for segment steps: a signed 24-bit displacement
// over an unsigned 16-bit duration, quotient truncated toward zero. One
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module msps_div
    import msps_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                    busy_reg;
    logic                    done_reg;
    logic                    neg_reg;
    logic [DIV_CNT_W-1:0]    cnt_reg;
    logic [STEP_W-1:0]       quo_reg;
    logic [TICKS_W:0]        rem_reg;
    logic [TICKS_W-1:0]      div_reg;
    logic signed [STEP_W-1:0] result_reg;

    logic [TICKS_W:0]        rem_shift;
    logic                    fits;
    logic [STEP_W-1:0]       magnitude;

    // magnitude of the incoming dividend, -2^23 maps to 2^23 unsigned
    assign magnitude = req.dividend[STEP_W-1] ? (~req.dividend + 1'b1) : req.dividend;

    // one restoring step: shift in the next dividend bit and try a subtract
    assign rem_shift = {rem_reg[TICKS_W-1:0], quo_reg[STEP_W-1]};
    assign fits      = (rem_shift >= {1'b0, div_reg});

    // sequencer and datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(STEP_W);
                neg_reg  <= req.dividend[STEP_W-1];
                quo_reg  <= magnitude;
                rem_reg  <= '0;
                div_reg  <= req.divisor;
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg   <= 1'b0;
                    done_reg   <= 1'b1;
                    result_reg <= neg_reg ? (~quo_reg + 1'b1) : quo_reg;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                    quo_reg <= {quo_reg[STEP_W-2:0], fits};
                    rem_reg <= fits ? (rem_shift - {1'b0, div_reg}) : rem_shift;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = result_reg;

endmodule
